// ----- rtl/core/scb_pkg.sv -----
// ----------------------------------------------------------------------------
// scb_pkg
// Shared types and constants for the SATA command builder.
// ----------------------------------------------------------------------------
package scb_pkg;

   localparam int MAX_ENTRIES_DEF  = 8;
   localparam int CHUNK_BYTES_DEF  = 4194304;
   localparam int SLOT_COUNT_DEF   = 32;
   localparam int SECTOR_BYTES_DEF = 512;

   localparam int SIZE_W = 32;

   // request commands
   localparam logic [2:0] CMD_READ     = 3'd0;
   localparam logic [2:0] CMD_WRITE    = 3'd1;
   localparam logic [2:0] CMD_PACKET   = 3'd2;
   localparam logic [2:0] CMD_IDENTIFY = 3'd3;
   localparam logic [2:0] CMD_FLUSH    = 3'd4;

   // result status
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_SLOT = 2'd1;
   localparam logic [1:0] ST_BAD_LEN = 2'd2;
   localparam logic [1:0] ST_BAD_CMD = 2'd3;

   // result kinds
   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_PRDT   = 1'b1;

   // ATA opcodes
   localparam logic [7:0] ATA_READ_DMA_EXT  = 8'h25;
   localparam logic [7:0] ATA_WRITE_DMA_EXT = 8'h35;
   localparam logic [7:0] ATA_PACKET        = 8'hA0;
   localparam logic [7:0] ATA_ID_DEVICE     = 8'hEC;
   localparam logic [7:0] ATA_ID_PACKET     = 8'hA1;
   localparam logic [7:0] ATA_FLUSH_EXT     = 8'hEA;
   localparam logic [7:0] FIS_DEV_LBA       = 8'h40;
   localparam logic [7:0] FIS_FEAT_DMA      = 8'h01;
   localparam logic [15:0] PKT_BC_MASK      = 16'hFFFE;
   localparam logic [SIZE_W-1:0] IDENTIFY_BYTES = 32'd512;

   typedef struct packed {
      logic load;
      logic prep;
      logic count;
      logic sum;
      logic head;
      logic entry;
   } dp_cmd_type;

   typedef struct packed {
      logic empty;
      logic final_entry;
   } dp_sts_type;

endpackage

// ----- rtl/core/scb_ctrl.sv -----
// ----------------------------------------------------------------------------
// scb_ctrl
// Sequencer: request capture, header build, one PRDT word per cycle while the result is not stalled.
// ----------------------------------------------------------------------------
module scb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output scb_pkg::dp_cmd_type cmd,
   input  scb_pkg::dp_sts_type sts
);
   import scb_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PREP  = 3'd1;
   localparam logic [2:0] S_COUNT = 3'd2;
   localparam logic [2:0] S_SUM   = 3'd3;
   localparam logic [2:0] S_HEAD  = 3'd4;
   localparam logic [2:0] S_ENTRY = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_COUNT;
         end
         S_COUNT: begin
            cmd.count = 1'b1;
            state_in  = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_HEAD;
         end
         S_HEAD: begin
            if (out_free) begin
               cmd.head = 1'b1;
               state_in = sts.empty ? S_IDLE : S_ENTRY;
            end
         end
         S_ENTRY: begin
            if (out_free) begin
               cmd.entry = 1'b1;
               if (sts.final_entry) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = (cmd.head || cmd.entry) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while busy");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.prep, cmd.count, cmd.sum, cmd.head, cmd.entry}))
      else $error("more than one datapath command");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.head || cmd.entry) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output overwritten while stalled");

   a_entry_after_head: assert property (@(posedge clock) disable iff (reset)
      cmd.head && !sts.empty |=> state_ff == S_ENTRY)
      else $error("PRDT words lost after header");

endmodule

// ----- rtl/core/scb_datapath.sv -----
// ----------------------------------------------------------------------------
// scb_datapath
// Slot search, FIS fields, PRDT chunking and the result register.
// ----------------------------------------------------------------------------
module scb_datapath #(
   parameter int MAX_ENTRIES  = scb_pkg::MAX_ENTRIES_DEF,
   parameter int CHUNK_BYTES  = scb_pkg::CHUNK_BYTES_DEF,
   parameter int SLOT_COUNT   = scb_pkg::SLOT_COUNT_DEF,
   parameter int SECTOR_BYTES = scb_pkg::SECTOR_BYTES_DEF
) (
   input  logic                clock,
   input  scb_pkg::dp_cmd_type cmd,
   output scb_pkg::dp_sts_type sts,
   input  logic [2:0]          req_command,
   input  logic [47:0]         req_lba,
   input  logic [15:0]         req_sector_count,
   input  logic [63:0]         req_buf_addr,
   input  logic [31:0]         req_buf_size,
   input  logic [1:0]          req_packet_mode,
   input  logic [4:0]          req_packet_length,
   input  logic                req_atapi_device,
   input  logic [31:0]         req_busy_slots,
   output logic                rsp_kind,
   output logic [1:0]          rsp_status,
   output logic [4:0]          rsp_slot,
   output logic                rsp_write_flag,
   output logic                rsp_atapi_flag,
   output logic [21:0]         rsp_entry_count,
   output logic [7:0]          rsp_fis_command,
   output logic [7:0]          rsp_fis_features,
   output logic [7:0]          rsp_fis_device,
   output logic [63:0]         rsp_addr_or_lba,
   output logic [15:0]         rsp_fis_count,
   output logic                rsp_last
);
   import scb_pkg::*;

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   // captured request
   logic [2:0]  cmd_ff;
   logic [47:0] lba_ff;
   logic [15:0] blk_ff;
   logic [63:0] baddr_ff;
   logic [31:0] bsize_ff;
   logic [1:0]  mode_ff;
   logic [4:0]  plen_ff;
   logic        adev_ff;
   logic [31:0] busy_ff;

   // header build
   logic [1:0]        status_ff;
   logic [4:0]        slot_ff;
   logic              hwr_ff, hatapi_ff;
   logic [7:0]        hcmd_ff, hfeat_ff, hdev_ff;
   logic [63:0]       haddr_ff;
   logic [15:0]       hfcnt_ff;
   logic [SIZE_W-1:0] remain_ff, remain_in;
   logic [63:0]       addr_ff, addr_in;
   logic [MAX_ENTRIES-1:0] thr_ff;
   logic [CNT_W-1:0]  n_ff, ent_ff;

   // result register
   logic        kind_ff, wr_ff, atapi_ff, last_ff;
   logic [1:0]  ost_ff;
   logic [4:0]  oslot_ff;
   logic [21:0] ecnt_ff;
   logic [7:0]  ocmd_ff, ofeat_ff, odev_ff;
   logic [63:0] oaddr_ff;
   logic [15:0] ofcnt_ff;

   logic              slot_free;
   logic [4:0]        slot_pick;
   logic [1:0]        status_in;
   logic              hwr_in, hatapi_in;
   logic [7:0]        hcmd_in, hfeat_in, hdev_in;
   logic [63:0]       haddr_in;
   logic [15:0]       hfcnt_in;
   logic [SIZE_W-1:0] size_in;
   logic [15:0]       pkt_bc;
   logic [MAX_ENTRIES-1:0] thr_in;
   logic [SIZE_W-1:0] chunk;
   logic              ok;

   always_comb begin
      slot_free = 1'b0;
      slot_pick = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            slot_free = 1'b1;
            slot_pick = 5'(i);
         end
      end
   end

   always_comb begin
      if (cmd_ff > CMD_FLUSH) begin
         status_in = ST_BAD_CMD;
      end else if (cmd_ff == CMD_PACKET && (plen_ff == 5'd0 || plen_ff > 5'd16)) begin
         status_in = ST_BAD_LEN;
      end else if (!slot_free) begin
         status_in = ST_NO_SLOT;
      end else begin
         status_in = ST_OK;
      end
   end

   assign pkt_bc = (bsize_ff != 32'd0) ? (bsize_ff[15:0] & PKT_BC_MASK) : PKT_BC_MASK;

   always_comb begin
      hwr_in    = 1'b0;
      hatapi_in = 1'b0;
      hcmd_in   = '0;
      hfeat_in  = '0;
      hdev_in   = '0;
      haddr_in  = '0;
      hfcnt_in  = '0;
      size_in   = '0;
      case (cmd_ff)
         CMD_READ, CMD_WRITE: begin
            size_in  = {16'd0, blk_ff} * SIZE_W'(SECTOR_BYTES);
            hwr_in   = (cmd_ff == CMD_WRITE);
            hcmd_in  = (cmd_ff == CMD_WRITE) ? ATA_WRITE_DMA_EXT : ATA_READ_DMA_EXT;
            hdev_in  = FIS_DEV_LBA;
            haddr_in = {16'd0, lba_ff};
            hfcnt_in = blk_ff;
         end
         CMD_PACKET: begin
            size_in   = bsize_ff;
            hwr_in    = mode_ff[1];
            hatapi_in = 1'b1;
            hcmd_in   = ATA_PACKET;
            if (mode_ff[0]) begin
               hfeat_in = FIS_FEAT_DMA;
            end else begin
               haddr_in = {40'd0, pkt_bc, 8'd0};
            end
         end
         CMD_IDENTIFY: begin
            size_in = IDENTIFY_BYTES;
            hcmd_in = adev_ff ? ATA_ID_PACKET : ATA_ID_DEVICE;
         end
         CMD_FLUSH: begin
            hcmd_in = ATA_FLUSH_EXT;
         end
         default: ;
      endcase
   end

   assign ok = (status_in == ST_OK);

   for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_thr
      localparam logic [SIZE_W:0] THR = (SIZE_W + 1)'(k) * (SIZE_W + 1)'(CHUNK_BYTES);
      assign thr_in[k] = ({1'b0, remain_ff} > THR);
   end

   assign chunk     = (remain_ff > SIZE_W'(CHUNK_BYTES)) ? SIZE_W'(CHUNK_BYTES) : remain_ff;
   assign remain_in = remain_ff - chunk;
   assign addr_in   = addr_ff + {32'd0, chunk};

   assign sts.empty       = (n_ff == '0);
   assign sts.final_entry = (CNT_W'(ent_ff + 1'b1) == n_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_command;
         lba_ff   <= req_lba;
         blk_ff   <= req_sector_count;
         baddr_ff <= req_buf_addr;
         bsize_ff <= req_buf_size;
         mode_ff  <= req_packet_mode;
         plen_ff  <= req_packet_length;
         adev_ff  <= req_atapi_device;
         busy_ff  <= req_busy_slots;
      end
      if (cmd.prep) begin
         status_ff <= status_in;
         slot_ff   <= ok ? slot_pick : 5'd0;
         hwr_ff    <= ok && hwr_in;
         hatapi_ff <= ok && hatapi_in;
         hcmd_ff   <= ok ? hcmd_in : 8'd0;
         hfeat_ff  <= ok ? hfeat_in : 8'd0;
         hdev_ff   <= ok ? hdev_in : 8'd0;
         haddr_ff  <= ok ? haddr_in : 64'd0;
         hfcnt_ff  <= ok ? hfcnt_in : 16'd0;
         remain_ff <= (ok && baddr_ff != 64'd0) ? size_in : '0;
         addr_ff   <= baddr_ff;
      end
      if (cmd.count) begin
         thr_ff <= thr_in;
      end
      if (cmd.sum) begin
         n_ff   <= CNT_W'($countones(thr_ff));
         ent_ff <= '0;
      end
      if (cmd.head) begin
         kind_ff  <= KIND_HEADER;
         ost_ff   <= status_ff;
         oslot_ff <= slot_ff;
         wr_ff    <= hwr_ff;
         atapi_ff <= hatapi_ff;
         ecnt_ff  <= 22'(n_ff);
         ocmd_ff  <= hcmd_ff;
         ofeat_ff <= hfeat_ff;
         odev_ff  <= hdev_ff;
         oaddr_ff <= haddr_ff;
         ofcnt_ff <= hfcnt_ff;
         last_ff  <= (n_ff == '0);
      end
      if (cmd.entry) begin
         kind_ff   <= KIND_PRDT;
         ost_ff    <= ST_OK;
         oslot_ff  <= slot_ff;
         wr_ff     <= 1'b0;
         atapi_ff  <= 1'b0;
         ecnt_ff   <= 22'(chunk - 1'b1);
         ocmd_ff   <= '0;
         ofeat_ff  <= '0;
         odev_ff   <= '0;
         oaddr_ff  <= addr_ff;
         ofcnt_ff  <= '0;
         last_ff   <= sts.final_entry;
         remain_ff <= remain_in;
         addr_ff   <= addr_in;
         ent_ff    <= CNT_W'(ent_ff + 1'b1);
      end
   end

   assign rsp_kind         = kind_ff;
   assign rsp_status       = ost_ff;
   assign rsp_slot         = oslot_ff;
   assign rsp_write_flag   = wr_ff;
   assign rsp_atapi_flag   = atapi_ff;
   assign rsp_entry_count  = ecnt_ff;
   assign rsp_fis_command  = ocmd_ff;
   assign rsp_fis_features = ofeat_ff;
   assign rsp_fis_device   = odev_ff;
   assign rsp_addr_or_lba  = oaddr_ff;
   assign rsp_fis_count    = ofcnt_ff;
   assign rsp_last         = last_ff;

   a_entry_has_data: assert property (@(posedge clock)
      cmd.entry |-> remain_ff != '0)
      else $error("PRDT word with no bytes left");

   a_entry_ok: assert property (@(posedge clock)
      cmd.entry |-> status_ff == ST_OK)
      else $error("PRDT word after rejected request");

   a_count_bound: assert property (@(posedge clock)
      cmd.head |-> n_ff <= CNT_W'(MAX_ENTRIES))
      else $error("PRDT count above limit");

endmodule

// ----- rtl/core/sata_command_builder_top.sv -----
// ----------------------------------------------------------------------------
// sata_command_builder_top
// Builds an AHCI command header with FIS and its PRDT words per request.
// ----------------------------------------------------------------------------
//  channel | prefix | handshake        | word
//  request | req_   | valid / stall    | command, LBA, buffer, busy slots
//  result  | rsp_   | valid / stall    | header or one PRDT entry
//
//  One request at a time. After the request is taken the header is built in
//  the steps decode, chunk compare, count and header load, then one PRDT word
//  per cycle while the result is not stalled.
//  A stalled result word holds; the sequencer waits on the result register.
//  Synchronous reset clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
module sata_command_builder_top #(
   parameter int MAX_ENTRIES  = scb_pkg::MAX_ENTRIES_DEF,
   parameter int CHUNK_BYTES  = scb_pkg::CHUNK_BYTES_DEF,
   parameter int SLOT_COUNT   = scb_pkg::SLOT_COUNT_DEF,
   parameter int SECTOR_BYTES = scb_pkg::SECTOR_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [47:0] req_lba,
   input  logic [15:0] req_sector_count,
   input  logic [63:0] req_buf_addr,
   input  logic [31:0] req_buf_size,
   input  logic [1:0]  req_packet_mode,
   input  logic [4:0]  req_packet_length,
   input  logic        req_atapi_device,
   input  logic [31:0] req_busy_slots,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_slot,
   output logic        rsp_write_flag,
   output logic        rsp_atapi_flag,
   output logic [21:0] rsp_entry_count,
   output logic [7:0]  rsp_fis_command,
   output logic [7:0]  rsp_fis_features,
   output logic [7:0]  rsp_fis_device,
   output logic [63:0] rsp_addr_or_lba,
   output logic [15:0] rsp_fis_count,
   output logic        rsp_last
);
   import scb_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   scb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

   scb_datapath #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .CHUNK_BYTES  (CHUNK_BYTES),
      .SLOT_COUNT   (SLOT_COUNT),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_datapath (
      .clock             (clock),
      .cmd               (dp_cmd),
      .sts               (dp_sts),
      .req_command       (req_command),
      .req_lba           (req_lba),
      .req_sector_count  (req_sector_count),
      .req_buf_addr      (req_buf_addr),
      .req_buf_size      (req_buf_size),
      .req_packet_mode   (req_packet_mode),
      .req_packet_length (req_packet_length),
      .req_atapi_device  (req_atapi_device),
      .req_busy_slots    (req_busy_slots),
      .rsp_kind          (rsp_kind),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_write_flag    (rsp_write_flag),
      .rsp_atapi_flag    (rsp_atapi_flag),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_fis_command   (rsp_fis_command),
      .rsp_fis_features  (rsp_fis_features),
      .rsp_fis_device    (rsp_fis_device),
      .rsp_addr_or_lba   (rsp_addr_or_lba),
      .rsp_fis_count     (rsp_fis_count),
      .rsp_last          (rsp_last)
   );

endmodule
